[rtl/core/tis_pkg.sv]
// Shared constants, types and helper functions for the triangle isoline block.
// Used by tis_div_lane.sv and triangle_isoline_segment.sv; depends on nothing.
package tis_pkg;

  // Coordinate and value width, Q16.16.
  localparam int CW = 32;
  // Width of an exact difference of two coordinates.
  localparam int DW = CW + 1;
  // Width of a weight times an edge length.
  localparam int PW = 2 * CW;
  // Quotient width: the offset is below the edge length.
  localparam int QW = CW + 1;
  // One quotient bit is resolved per divider stage.
  localparam int DIV_STAGES = QW;
  // Tolerance register width.
  localparam int TOLW = 16;
  // Cycles from the accepting edge to the edge that samples the done strobe.
  localparam int LATENCY = DIV_STAGES + 6;

  // Configuration register indexes.
  localparam logic REG_ISO_LEVEL = 1'b0;
  localparam logic REG_EQ_TOL    = 1'b1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic [DW-1:0]        mag_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t f;
  } vertex_t;

  // Length and direction of one triangle edge in x and y.
  typedef struct packed {
    mag_t mx;
    mag_t my;
    logic nx;
    logic ny;
  } edge_t;

  // Operands of one interpolated coordinate: base + sign * num * mag / den.
  typedef struct packed {
    logic [CW-1:0] num;
    logic [CW-1:0] den;
    mag_t          mag;
    logic          neg;
    coord_t        base;
  } lane_t;

  // Magnitude of an exact difference.
  function automatic mag_t abs_diff(input diff_t d);
    abs_diff = d[DW-1] ? mag_t'(-d) : mag_t'(d);
  endfunction

  // Exact difference a - b.
  function automatic diff_t sub_ext(input coord_t a, input coord_t b);
    sub_ext = diff_t'({a[CW-1], a}) - diff_t'({b[CW-1], b});
  endfunction

endpackage

[rtl/core/triangle_isoline_segment.sv]
// Top level: iso-level contour segment through one triangle per word.
// Depends on tis_pkg and tis_div_lane.
//
//  channel  | handshake            | ports
//  ---------+----------------------+--------------------------------------------
//  input    | start & !busy        | vertex_{a,b,c}_{x,y,value}
//  result   | done (one cycle)     | has_segment, start_x, start_y, end_x, end_y
//  config   | cfg_we               | cfg_index, cfg_data
//
// One word enters per cycle while busy is low; its result passes through the 33-stage
// divider lanes and six other stages.
// busy is high only during reset. rst clears the valid bits, done and the configuration registers.
// The result side has no stall, so the pipeline advances every cycle.
module triangle_isoline_segment (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [tis_pkg::CW-1:0]        cfg_data,
  input  logic signed [tis_pkg::CW-1:0] vertex_a_x,
  input  logic signed [tis_pkg::CW-1:0] vertex_a_y,
  input  logic signed [tis_pkg::CW-1:0] vertex_a_value,
  input  logic signed [tis_pkg::CW-1:0] vertex_b_x,
  input  logic signed [tis_pkg::CW-1:0] vertex_b_y,
  input  logic signed [tis_pkg::CW-1:0] vertex_b_value,
  input  logic signed [tis_pkg::CW-1:0] vertex_c_x,
  input  logic signed [tis_pkg::CW-1:0] vertex_c_y,
  input  logic signed [tis_pkg::CW-1:0] vertex_c_value,
  output logic                          done,
  output logic                          has_segment,
  output logic signed [tis_pkg::CW-1:0] start_x,
  output logic signed [tis_pkg::CW-1:0] start_y,
  output logic signed [tis_pkg::CW-1:0] end_x,
  output logic signed [tis_pkg::CW-1:0] end_y
);

  typedef struct packed {
    logic                       has;
    tis_pkg::coord_t [3:0]      base;
    logic [3:0]                 neg;
  } side_t;

  logic                  accept;
  tis_pkg::coord_t       iso_level;
  logic [tis_pkg::TOLW-1:0] eq_tolerance;
  tis_pkg::mag_t         tol;

  assign busy   = rst;
  assign accept = start && !busy;
  assign tol    = tis_pkg::mag_t'(eq_tolerance);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level    <= '0;
      eq_tolerance <= tis_pkg::TOLW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tis_pkg::REG_ISO_LEVEL: iso_level    <= cfg_data;
        tis_pkg::REG_EQ_TOL:    eq_tolerance <= cfg_data[tis_pkg::TOLW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: input capture.
  logic              s0_valid;
  tis_pkg::vertex_t  s0_v [0:2];

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else     s0_valid <= accept;
  end

  always_ff @(posedge clk) begin
    s0_v[0] <= '{x: vertex_a_x, y: vertex_a_y, f: vertex_a_value};
    s0_v[1] <= '{x: vertex_b_x, y: vertex_b_y, f: vertex_b_value};
    s0_v[2] <= '{x: vertex_c_x, y: vertex_c_y, f: vertex_c_value};
  end

  // Stage 1: flat test and the three-compare stable sort by value.
  logic              flat;
  tis_pkg::vertex_t  st_a, st_b, st_c, tmp;
  logic              s1_valid, s1_flat;
  tis_pkg::vertex_t  s1_p [0:2];

  always_comb begin
    flat = (tis_pkg::abs_diff(tis_pkg::sub_ext(s0_v[0].f, s0_v[1].f)) < tol) &&
           (tis_pkg::abs_diff(tis_pkg::sub_ext(s0_v[1].f, s0_v[2].f)) < tol);
    tmp  = '0;
    st_a = s0_v[0];
    st_b = s0_v[1];
    st_c = s0_v[2];
    if (st_b.f > st_c.f) begin
      tmp = st_b; st_b = st_c; st_c = tmp;
    end
    if (st_a.f > st_b.f) begin
      tmp = st_a; st_a = st_b; st_b = tmp;
    end
    if (st_b.f > st_c.f) begin
      tmp = st_b; st_b = st_c; st_c = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= s0_valid;
  end

  always_ff @(posedge clk) begin
    s1_flat <= flat;
    s1_p[0] <= st_a;
    s1_p[1] <= st_b;
    s1_p[2] <= st_c;
  end

  // Stage 2: level and value differences, edge lengths.
  logic              s2_valid, s2_flat;
  tis_pkg::vertex_t  s2_p [0:2];
  tis_pkg::diff_t    s2_dv0, s2_dv1, s2_dv2, s2_d10, s2_d20, s2_d21;
  tis_pkg::edge_t    s2_e [0:2];

  function automatic tis_pkg::edge_t make_edge(input tis_pkg::vertex_t pa,
                                               input tis_pkg::vertex_t pb);
    tis_pkg::diff_t dx;
    tis_pkg::diff_t dy;
    dx = tis_pkg::sub_ext(pb.x, pa.x);
    dy = tis_pkg::sub_ext(pb.y, pa.y);
    make_edge.mx = tis_pkg::abs_diff(dx);
    make_edge.my = tis_pkg::abs_diff(dy);
    make_edge.nx = dx[tis_pkg::DW-1];
    make_edge.ny = dy[tis_pkg::DW-1];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_flat <= s1_flat;
    s2_p    <= s1_p;
    s2_dv0  <= tis_pkg::sub_ext(iso_level, s1_p[0].f);
    s2_dv1  <= tis_pkg::sub_ext(iso_level, s1_p[1].f);
    s2_dv2  <= tis_pkg::sub_ext(iso_level, s1_p[2].f);
    s2_d10  <= tis_pkg::sub_ext(s1_p[1].f, s1_p[0].f);
    s2_d20  <= tis_pkg::sub_ext(s1_p[2].f, s1_p[0].f);
    s2_d21  <= tis_pkg::sub_ext(s1_p[2].f, s1_p[1].f);
    s2_e[0] <= make_edge(s1_p[0], s1_p[1]);
    s2_e[1] <= make_edge(s1_p[0], s1_p[2]);
    s2_e[2] <= make_edge(s1_p[1], s1_p[2]);
  end

  // Stage 3: case selection and lane operands.
  // Lanes: 0 start x, 1 start y, 2 end x, 3 end y.
  logic              has;
  tis_pkg::lane_t    lane [0:3];
  logic              s3_valid, s3_has;
  tis_pkg::lane_t    s3_lane [0:3];

  function automatic tis_pkg::lane_t fixed_pt(input tis_pkg::coord_t p);
    fixed_pt.num  = '0;
    fixed_pt.den  = tis_pkg::CW'(1);
    fixed_pt.mag  = '0;
    fixed_pt.neg  = 1'b0;
    fixed_pt.base = p;
  endfunction

  function automatic tis_pkg::lane_t interp(input tis_pkg::coord_t p,
                                            input tis_pkg::diff_t num,
                                            input tis_pkg::diff_t den,
                                            input tis_pkg::mag_t mag,
                                            input logic neg);
    interp.num  = num[tis_pkg::CW-1:0];
    interp.den  = den[tis_pkg::CW-1:0];
    interp.mag  = mag;
    interp.neg  = neg;
    interp.base = p;
  endfunction

  always_comb begin
    has = 1'b0;
    for (int k = 0; k < 4; k++) lane[k] = fixed_pt('0);
    if (s2_flat || s2_dv0[tis_pkg::DW-1] ||
        (!s2_dv2[tis_pkg::DW-1] && s2_dv2 != '0)) begin
      has = 1'b0;
    end else if (tis_pkg::abs_diff(s2_dv0) < tol) begin
      // Level at the lowest value: the whole low edge when the lower values match.
      if (tis_pkg::mag_t'(s2_d10) >= tol) begin
        has = 1'b0;
      end else begin
        has     = 1'b1;
        lane[0] = fixed_pt(s2_p[0].x);
        lane[1] = fixed_pt(s2_p[0].y);
        lane[2] = fixed_pt(s2_p[1].x);
        lane[3] = fixed_pt(s2_p[1].y);
      end
    end else if (tis_pkg::abs_diff(s2_dv1) < tol) begin
      // Level at the middle value: the whole upper edge when the upper values match.
      if (tis_pkg::mag_t'(s2_d21) < tol) begin
        has     = 1'b1;
        lane[0] = fixed_pt(s2_p[1].x);
        lane[1] = fixed_pt(s2_p[1].y);
        lane[2] = fixed_pt(s2_p[2].x);
        lane[3] = fixed_pt(s2_p[2].y);
      end
    end else if (tis_pkg::abs_diff(s2_dv2) < tol) begin
      has = 1'b0;
    end else if (s2_dv1[tis_pkg::DW-1]) begin
      has     = 1'b1;
      lane[0] = interp(s2_p[0].x, s2_dv0, s2_d10, s2_e[0].mx, s2_e[0].nx);
      lane[1] = interp(s2_p[0].y, s2_dv0, s2_d10, s2_e[0].my, s2_e[0].ny);
      lane[2] = interp(s2_p[0].x, s2_dv0, s2_d20, s2_e[1].mx, s2_e[1].nx);
      lane[3] = interp(s2_p[0].y, s2_dv0, s2_d20, s2_e[1].my, s2_e[1].ny);
    end else if (s2_dv2[tis_pkg::DW-1]) begin
      has     = 1'b1;
      lane[0] = interp(s2_p[1].x, s2_dv1, s2_d21, s2_e[2].mx, s2_e[2].nx);
      lane[1] = interp(s2_p[1].y, s2_dv1, s2_d21, s2_e[2].my, s2_e[2].ny);
      lane[2] = interp(s2_p[0].x, s2_dv0, s2_d20, s2_e[1].mx, s2_e[1].nx);
      lane[3] = interp(s2_p[0].y, s2_dv0, s2_d20, s2_e[1].my, s2_e[1].ny);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    s3_has  <= has;
    s3_lane <= lane;
  end

  // Stage 4: weight times edge length, one multiplier per lane.
  // The weight is below one, so the product stays under 2**PW.
  logic                       s4_valid;
  side_t                      s4_side;
  logic [tis_pkg::PW-1:0]     s4_prod [0:3];
  logic [tis_pkg::CW-1:0]     s4_den  [0:3];
  logic [tis_pkg::PW-1:0]     prod_full [0:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_full[k] = tis_pkg::PW'(s3_lane[k].num) * tis_pkg::PW'(s3_lane[k].mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    s4_side.has <= s3_has;
    for (int k = 0; k < 4; k++) begin
      s4_prod[k]      <= prod_full[k];
      s4_den[k]       <= s3_lane[k].den;
      s4_side.base[k] <= s3_lane[k].base;
      s4_side.neg[k]  <= s3_lane[k].neg;
    end
  end

  // Divider lanes with a matching delay line for valid and side data.
  logic [tis_pkg::QW-1:0]          quo [0:3];
  logic [tis_pkg::DIV_STAGES-1:0]  dl_valid;
  side_t                           dl_side [0:tis_pkg::DIV_STAGES-1];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    tis_div_lane u_div (
      .clk      (clk),
      .dividend (s4_prod[k]),
      .divisor  (s4_den[k]),
      .quotient (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) dl_valid <= '0;
    else     dl_valid <= {dl_valid[tis_pkg::DIV_STAGES-2:0], s4_valid};
  end

  always_ff @(posedge clk) begin
    dl_side[0] <= s4_side;
    for (int i = 1; i < tis_pkg::DIV_STAGES; i++) dl_side[i] <= dl_side[i-1];
  end

  // Output stage: apply the offset toward the far vertex.
  side_t                         fin;
  tis_pkg::coord_t               pt [0:3];
  logic signed [tis_pkg::DW:0]   sum;

  assign fin = dl_side[tis_pkg::DIV_STAGES-1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum = {{2{fin.base[k][tis_pkg::CW-1]}}, fin.base[k]};
      if (fin.neg[k]) sum = sum - (tis_pkg::DW+1)'(quo[k]);
      else            sum = sum + (tis_pkg::DW+1)'(quo[k]);
      pt[k] = fin.has ? sum[tis_pkg::CW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dl_valid[tis_pkg::DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    has_segment <= fin.has;
    start_x     <= pt[0];
    start_y     <= pt[1];
    end_x       <= pt[2];
    end_y       <= pt[3];
  end

`ifndef SYNTHESIS
  // Every accepted word comes out after the fixed pipeline latency.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(tis_pkg::LATENCY) done)
    else $error("accepted word did not produce a result on time");

  // A result without a segment carries zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    (done && !has_segment) |->
      (start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0))
    else $error("empty result carries nonzero coordinates");

  // A strobe needs a word in the last divider stage in the cycle before.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(dl_valid[tis_pkg::DIV_STAGES-1]))
    else $error("result strobe without a word in flight");
`endif

endmodule

[rtl/core/tis_div_lane.sv]
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on tis_pkg; the quotient must fit in tis_pkg::QW bits.
module tis_div_lane (
  input  logic                       clk,
  input  logic [tis_pkg::PW-1:0]     dividend,
  input  logic [tis_pkg::CW-1:0]     divisor,
  output logic [tis_pkg::QW-1:0]     quotient
);

  logic [tis_pkg::CW-1:0] rem_s [0:tis_pkg::DIV_STAGES];
  logic [tis_pkg::QW-1:0] lo_s  [0:tis_pkg::DIV_STAGES];
  logic [tis_pkg::QW-1:0] q_s   [0:tis_pkg::DIV_STAGES];
  logic [tis_pkg::CW-1:0] d_s   [0:tis_pkg::DIV_STAGES];

  // The upper dividend bits are already below the divisor.
  assign rem_s[0] = {1'b0, dividend[tis_pkg::PW-1:tis_pkg::QW]};
  assign lo_s[0]  = dividend[tis_pkg::QW-1:0];
  assign q_s[0]   = '0;
  assign d_s[0]   = divisor;

  for (genvar i = 0; i < tis_pkg::DIV_STAGES; i++) begin : g_stage
    logic [tis_pkg::CW:0]   trial;
    logic [tis_pkg::CW:0]   diff;
    logic                   ge;

    // Shift in the next dividend bit and subtract when it fits.
    always_comb begin
      trial = {rem_s[i], lo_s[i][tis_pkg::QW-1]};
      diff  = trial - {1'b0, d_s[i]};
      ge    = (trial >= {1'b0, d_s[i]});
    end

    always_ff @(posedge clk) begin
      rem_s[i+1] <= ge ? diff[tis_pkg::CW-1:0] : trial[tis_pkg::CW-1:0];
      lo_s[i+1]  <= {lo_s[i][tis_pkg::QW-2:0], 1'b0};
      q_s[i+1]   <= {q_s[i][tis_pkg::QW-2:0], ge};
      d_s[i+1]   <= d_s[i];
    end
  end

  assign quotient = q_s[tis_pkg::DIV_STAGES];

endmodule

[tb/tb_triangle_isoline_segment.sv]
// Testbench for triangle_isoline_segment: directed and random triangles
// checked against an in-bench contour segment predictor.
// Depends on tis_pkg and the triangle_isoline_segment RTL.
module tb_triangle_isoline_segment;
  timeunit 1ns;
  timeprecision 1ps;
  import tis_pkg::*;

  typedef struct {
    logic   has;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } segment_t;

  logic   clk, rst, start, busy, cfg_we, cfg_index, done, has_segment;
  logic [CW-1:0] cfg_data;
  coord_t vertex_a_x, vertex_a_y, vertex_a_value;
  coord_t vertex_b_x, vertex_b_y, vertex_b_value;
  coord_t vertex_c_x, vertex_c_y, vertex_c_value;
  coord_t start_x, start_y, end_x, end_y;

  // Shadow copy of the configuration registers.
  longint   level_q;
  longint   tol_q;
  segment_t expected_segments[$];
  int       failures = 0;

  triangle_isoline_segment dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit within_tol(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d < tol_q;
  endfunction

  function automatic bit above_tol(longint a, longint b);
    longint d;
    d = a - b;
    return d >= 0 && d >= tol_q;
  endfunction

  // Point on edge pa-pb at weight num/den, quotient truncated toward zero.
  function automatic coord_t edge_point(longint pa, longint pb, longint num, longint den);
    longint       dx, r;
    logic [127:0] prod, q;
    dx = pb - pa;
    if (den <= 0 || num < 0) return coord_t'(pa);
    prod = 128'(num) * 128'(dx < 0 ? -dx : dx);
    q = prod / 128'(den);
    r = dx < 0 ? pa - longint'(q) : pa + longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return coord_t'(r);
  endfunction

  // Expected contour segment through one triangle.
  function automatic segment_t isoline_segment(vertex_t vt[3]);
    segment_t s;
    longint   px[3], py[3], f[3];
    int       a, b, c, t;
    longint   f0, f1, f2, v;
    s = '{1'b1, '0, '0, '0, '0};
    a = 0; b = 1; c = 2; v = level_q;
    for (int k = 0; k < 3; k++) begin
      px[k] = vt[k].x; py[k] = vt[k].y; f[k] = vt[k].f;
    end
    if (within_tol(f[0], f[1]) && within_tol(f[1], f[2])) s.has = 1'b0;
    // Stable three-compare sort by value.
    if (f[b] > f[c]) begin t = b; b = c; c = t; end
    if (f[a] > f[b]) begin t = a; a = b; b = t; end
    if (f[b] > f[c]) begin t = b; b = c; c = t; end
    f0 = f[a]; f1 = f[b]; f2 = f[c];
    if (s.has) begin
      if (v < f0 || v > f2) begin
        s.has = 1'b0;
      end else if (within_tol(v, f0)) begin
        if (above_tol(f1, f0)) s.has = 1'b0;
        else s = '{1'b1, coord_t'(px[a]), coord_t'(py[a]), coord_t'(px[b]), coord_t'(py[b])};
      end else if (within_tol(v, f1)) begin
        if (!within_tol(f1, f2)) s.has = 1'b0;
        else s = '{1'b1, coord_t'(px[b]), coord_t'(py[b]), coord_t'(px[c]), coord_t'(py[c])};
      end else if (within_tol(v, f2)) begin
        s.has = 1'b0;
      end else if (v < f1) begin
        s.sx = edge_point(px[a], px[b], v - f0, f1 - f0);
        s.sy = edge_point(py[a], py[b], v - f0, f1 - f0);
        s.ex = edge_point(px[a], px[c], v - f0, f2 - f0);
        s.ey = edge_point(py[a], py[c], v - f0, f2 - f0);
      end else if (v < f2) begin
        s.sx = edge_point(px[b], px[c], v - f1, f2 - f1);
        s.sy = edge_point(py[b], py[c], v - f1, f2 - f1);
        s.ex = edge_point(px[a], px[c], v - f0, f2 - f0);
        s.ey = edge_point(py[a], py[c], v - f0, f2 - f0);
      end else begin
        s.has = 1'b0;
      end
    end
    if (!s.has) s = '{1'b0, '0, '0, '0, '0};
    return s;
  endfunction

  // Result checker: every done word is compared with the oldest expectation.
  always @(posedge clk) begin
    segment_t e;
    if (!rst && done) begin
      if (expected_segments.size() == 0) begin
        $error("result word with no expectation waiting");
        failures++;
      end else begin
        e = expected_segments.pop_front();
        if (has_segment !== e.has) begin
          $error("has_segment: expected %0d, actual %0d", e.has, has_segment);
          failures++;
        end
        if (start_x !== e.sx) begin
          $error("start_x: expected %0d, actual %0d", e.sx, start_x);
          failures++;
        end
        if (start_y !== e.sy) begin
          $error("start_y: expected %0d, actual %0d", e.sy, start_y);
          failures++;
        end
        if (end_x !== e.ex) begin
          $error("end_x: expected %0d, actual %0d", e.ex, end_x);
          failures++;
        end
        if (end_y !== e.ey) begin
          $error("end_y: expected %0d, actual %0d", e.ey, end_y);
          failures++;
        end
      end
    end
  end

  // Send one triangle word; start stays high until an idle gap lowers it.
  task automatic send_triangle(vertex_t vt[3]);
    @(negedge clk);
    {vertex_a_x, vertex_a_y, vertex_a_value} <= vt[0];
    {vertex_b_x, vertex_b_y, vertex_b_value} <= vt[1];
    {vertex_c_x, vertex_c_y, vertex_c_value} <= vt[2];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_segments = {expected_segments, isoline_segment(vt)};
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drain all results, then write one register while the block is idle.
  task automatic write_reg(logic idx, logic [CW-1:0] data);
    idle_cycles(1);
    while (expected_segments.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ISO_LEVEL) level_q = longint'(coord_t'(data));
    else tol_q = data[TOLW-1:0];
  endtask

  task automatic send_values(longint fa, longint fb, longint fc);
    vertex_t vt[3];
    vt[0] = '{coord_t'(32'h0001_0000), coord_t'(32'h0002_0000), coord_t'(fa)};
    vt[1] = '{coord_t'(-32'sh0003_0000), coord_t'(32'h0005_8000), coord_t'(fb)};
    vt[2] = '{coord_t'(32'h0007_0000), coord_t'(-32'sh0001_4000), coord_t'(fc)};
    send_triangle(vt);
  endtask

  // Directed cases for every rule of the contour selection.
  task automatic test_directed();
    vertex_t vt[3];
    write_reg(REG_ISO_LEVEL, 32'h0001_0000);
    write_reg(REG_EQ_TOL, 32'h0000_0100);
    send_values(32'h1_0000, 32'h1_0010, 32'h1_0020);   // flat triangle
    send_values(32'h2_0000, 32'h3_0000, 32'h4_0000);   // level below range
    send_values(-32'sh4_0000, -32'sh3_0000, 32'h0_8000); // level above range
    send_values(32'h1_0000, 32'h1_0004, 32'h5_0000);   // level at low, flat low edge
    send_values(32'h1_0000, 32'h2_0000, 32'h5_0000);   // level at low, rising
    send_values(32'h0_0000, 32'h1_0000, 32'h1_0008);   // level at middle, flat top
    send_values(32'h0_0000, 32'h1_0000, 32'h3_0000);   // level at middle, rising
    send_values(-32'sh2_0000, 32'h0_0000, 32'h1_0000); // level at top
    send_values(32'h0_0000, 32'h3_0000, 32'h4_0000);   // below middle
    send_values(32'h4_0000, 32'h0_0000, 32'h0_8000);   // above middle
    send_values(32'h3_0000, 32'h0_0000, 32'h3_0000);   // equal values, stable order
    send_values(32'h0_0000, 32'h3_0000, 32'h0_0000);
    // Extreme coordinates and values.
    vt[0] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    vt[1] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    vt[2] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000};
    send_triangle(vt);
    vt[2] = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'shFFFF_FFFF};
    send_triangle(vt);
    write_reg(REG_EQ_TOL, 32'hFFFF_0000);               // zero tolerance
    send_values(32'h1_0000, 32'h1_0000, 32'h1_0000);
    send_values(32'h1_0000, 32'h1_0000, 32'h2_0000);
    send_values(32'h0_0000, 32'h1_0000, 32'h1_0000);
    idle_cycles(1);
  endtask

  function automatic coord_t rand_value();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return coord_t'(level_q + $urandom_range(0, 8) - 4);
      2: return coord_t'(level_q + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
      default: return coord_t'(level_q + $urandom_range(0, 2 * tol_q + 2) - tol_q - 1);
    endcase
  endfunction

  function automatic coord_t rand_coord();
    if ($urandom_range(0, 1)) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
  endfunction

  // Random triangles in bursts with random gaps.
  task automatic test_random(int count);
    vertex_t vt[3];
    int      sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 24)) begin
        for (int k = 0; k < 3; k++) vt[k] = '{rand_coord(), rand_coord(), rand_value()};
        if ($urandom_range(0, 5) == 0) vt[$urandom_range(0, 2)].f = vt[$urandom_range(0, 2)].f;
        send_triangle(vt);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
    idle_cycles(1);
  endtask

  // Random phases over several register settings, extremes among them.
  task automatic test_settings();
    write_reg(REG_ISO_LEVEL, 32'h0000_0000);
    write_reg(REG_EQ_TOL, 32'h0000_0001);
    test_random(300);
    write_reg(REG_ISO_LEVEL, 32'h7FFF_FFFF);
    write_reg(REG_EQ_TOL, 32'h0000_0000);
    test_random(200);
    write_reg(REG_ISO_LEVEL, 32'h8000_0000);
    write_reg(REG_EQ_TOL, 32'h0000_FFFF);
    test_random(200);
    repeat (3) begin
      write_reg(REG_ISO_LEVEL, $urandom);
      write_reg(REG_EQ_TOL, $urandom);
      test_random(300);
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_index = REG_ISO_LEVEL; cfg_data = '0;
    {vertex_a_x, vertex_a_y, vertex_a_value} = '0;
    {vertex_b_x, vertex_b_y, vertex_b_value} = '0;
    {vertex_c_x, vertex_c_y, vertex_c_value} = '0;
    level_q = 0;
    tol_q = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_values(-32'sh1_0000, 32'h0_0000, 32'h2_0000);  // reset register values
    test_directed();
    test_settings();
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (failures == 0 && expected_segments.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/tis_pkg.sv
rtl/core/tis_div_lane.sv
rtl/core/triangle_isoline_segment.sv
tb/tb_triangle_isoline_segment.sv
